@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the serializer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge out of reset.
`define VFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define VFS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ rtl/core/vfs_pkg.sv @@
// Types, constants and code functions of the volume frame serializer.
`default_nettype none

package vfs_pkg;

    localparam int CHIP_W      = 3;
    localparam int VOL_W       = 8;
    localparam int CODE_BITS   = 8;
    localparam int FRAME_BITS  = 11;
    localparam int BIT_IDX_W   = $clog2(FRAME_BITS);

    localparam int CHIP_COUNT_DEFAULT  = 2;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic [CHIP_W-1:0]     t_chip;
    typedef logic [VOL_W-1:0]      t_vol;
    typedef logic [CODE_BITS-1:0]  t_code;
    typedef logic [FRAME_BITS-1:0] t_frame_bits;
    typedef logic [BIT_IDX_W-1:0]  t_bit_idx;

    // Register word index, taken from paddr[2].
    typedef enum logic {
        REG_MAX_VOLUME = 1'b0,
        REG_UNUSED     = 1'b1
    } t_reg_idx;

    localparam t_vol     MAX_VOLUME_RESET = t_vol'(87);
    localparam t_vol     VOL_OFFSET       = t_vol'(4);
    localparam t_code    CODE_TOP_BIT     = t_code'(1 << 7);
    localparam t_bit_idx LAST_BIT         = t_bit_idx'(FRAME_BITS - 1);

    typedef struct packed {
        t_chip       chip;
        t_frame_bits bits;
    } t_frame_req;

    // Over-range volume uses level zero, which gives code 8'h80; the offset add wraps in 8 bits.
    function automatic t_code vol_code(input t_vol v, input t_vol max_vol);
        t_vol a;
        a = (v > max_vol) ? '0 : t_vol'(v + VOL_OFFSET);
        return {a[2:0], 5'b0} | {2'b0, a[7:2]} | CODE_TOP_BIT;
    endfunction

    // Bit 0 goes out first: side, a one, code LSB first, closing one.
    function automatic t_frame_bits build_frame(input logic side, input t_code code);
        return {1'b1, code, 1'b1, side};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/vfs_if.sv @@
// Ready/valid channel interfaces for channel updates and serial bits.
`default_nettype none

interface vfs_in_if;
    import vfs_pkg::*;
    logic  valid;
    logic  ready;
    t_chip chip_index;
    logic  right_side;
    t_vol  volume;

    modport source (output valid, output chip_index, output right_side, output volume,
                    input ready);
    modport sink   (input valid, input chip_index, input right_side, input volume,
                    output ready);
endinterface

interface vfs_out_if;
    import vfs_pkg::*;
    logic  valid;
    logic  ready;
    t_chip clock_line;
    logic  data_bit;
    logic  latch_last;

    modport source (output valid, output clock_line, output data_bit, output latch_last,
                    input ready);
    modport sink   (input valid, input clock_line, input data_bit, input latch_last,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/vfs_front.sv @@
// Front end: accepts channel updates, drops unknown chips, encodes the frame.
`default_nettype none

module vfs_front #(
    parameter int CHIP_COUNT = vfs_pkg::CHIP_COUNT_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    vfs_in_if.sink              i_in,
    input  vfs_pkg::t_vol       i_max_volume,
    output logic                o_req_valid,
    output vfs_pkg::t_frame_req o_req,
    input  wire                 i_req_ready
);
    import vfs_pkg::*;

    localparam logic [CHIP_W:0] CHIP_LIMIT = (CHIP_W + 1)'(CHIP_COUNT);

    logic       r_valid, n_valid;
    t_frame_req r_req;
    logic       in_ready;
    logic       accept;
    logic       keep;

    assign in_ready   = !r_valid || i_req_ready;
    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;
    assign keep       = {1'b0, i_in.chip_index} < CHIP_LIMIT;

    always_comb begin
        n_valid = r_valid;
        if (in_ready) begin
            n_valid = accept && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.chip <= i_in.chip_index;
            r_req.bits <= build_frame(i_in.right_side, vol_code(i_in.volume, i_max_volume));
        end
    end

    assign o_req_valid = r_valid;
    assign o_req       = r_req;

endmodule

`default_nettype wire

@@ rtl/core/vfs_queue.sv @@
// Short request queue between the front end and the bit serializer.
`default_nettype none

`include "assert_macros.svh"

module vfs_queue #(
    parameter int DEPTH = vfs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  vfs_pkg::t_frame_req i_push_req,
    output logic                o_ready,
    output logic                o_valid,
    output vfs_pkg::t_frame_req o_req,
    input  wire                 i_pop
);
    import vfs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_frame_req       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_ready = r_cnt != CNT_FULL;
    assign o_valid = r_cnt != '0;
    assign o_req   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : PTR_W'(r_wr + 1'b1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : PTR_W'(r_rd + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_cnt = CNT_W'(r_cnt + 1'b1);
        end else if (do_pop && !do_push) begin
            n_cnt = CNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_req;
        end
    end

    `VFS_ASSERT(a_cnt_bound, r_cnt <= CNT_FULL, "queue count beyond depth")
    `VFS_ASSERT(a_no_push_full, (i_push && !o_ready) |=> $stable(r_wr),
                "write pointer moved on a full queue")
    `VFS_ASSERT(a_pop_empty, (!o_valid) |=> $stable(r_rd), "read pointer moved on an empty queue")

endmodule

`default_nettype wire

@@ rtl/core/vfs_back.sv @@
// Back end: shifts each frame out one bit per request on the output channel.
`default_nettype none

`include "assert_macros.svh"

module vfs_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_valid,
    input  vfs_pkg::t_frame_req i_req,
    output logic                o_pop,
    vfs_out_if.source           o_out
);
    import vfs_pkg::*;

    logic        r_busy, n_busy;
    t_frame_bits r_bits, n_bits;
    t_chip       r_chip, n_chip;
    t_bit_idx    r_idx, n_idx;
    logic        out_fire;
    logic        last;
    logic        load;

    assign out_fire = r_busy && o_out.ready;
    assign last     = r_idx == LAST_BIT;
    // Take the next frame while idle or as the closing bit leaves.
    assign load     = i_req_valid && (!r_busy || (out_fire && last));
    assign o_pop    = load;

    always_comb begin
        n_busy = r_busy;
        n_bits = r_bits;
        n_chip = r_chip;
        n_idx  = r_idx;
        if (load) begin
            n_busy = 1'b1;
            n_bits = i_req.bits;
            n_chip = i_req.chip;
            n_idx  = '0;
        end else if (out_fire) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_bits = r_bits >> 1;
                n_idx  = t_bit_idx'(r_idx + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_chip <= n_chip;
    end

    assign o_out.valid      = r_busy;
    assign o_out.clock_line = r_chip;
    assign o_out.data_bit   = r_bits[0];
    assign o_out.latch_last = r_busy && last;

    `VFS_ASSERT(a_latch_high, o_out.latch_last |-> o_out.data_bit,
                "latch bit must carry data high")
    `VFS_ASSERT(a_idx_bound, r_busy |-> (r_idx <= LAST_BIT), "bit index beyond frame")
    `VFS_ASSERT(a_idle_after_last, (out_fire && last && !i_req_valid) |=> !o_out.valid,
                "frame did not end after its closing bit")
    `VFS_ASSERT(a_mid_frame, (out_fire && !last) |=> (o_out.valid && !$stable(r_idx)),
                "frame stopped before its closing bit")

endmodule

`default_nettype wire

@@ rtl/core/volume_frame_serializer.sv @@
// Top level of the volume frame serializer: APB register, front end, queue, back end.
//
//   channel   dir   handshake      payload
//   i_in      in    valid/ready    chip_index[2:0], right_side, volume[7:0]
//   o_out     out   valid/ready    clock_line[2:0], data_bit, latch_last
//   apb       in    psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0]
//
// Each update for a known chip yields 11 bit requests, one per cycle while o_out is
// ready; the back end shift register limits the update rate.
// Updates for a chip at or above CHIP_COUNT are taken and dropped.
// An update reaches o_out through the front register, the queue and the shift register.
// i_rst_n is synchronous; it empties the queue, idles both ends, sets max_volume to 87.
// A stall on o_out holds the current bit; the front keeps taking updates until
// its register and the queue are full.
`default_nettype none

module volume_frame_serializer #(
    parameter int CHIP_COUNT  = vfs_pkg::CHIP_COUNT_DEFAULT,
    parameter int QUEUE_DEPTH = vfs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    vfs_in_if.sink                           i_in,
    vfs_out_if.source                        o_out,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [vfs_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire  [vfs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [vfs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import vfs_pkg::*;

    t_vol       r_max_volume;
    t_reg_idx   reg_idx;
    logic       cfg_write;
    logic       req_valid;
    t_frame_req req;
    logic       q_ready;
    logic       q_valid;
    t_frame_req q_req;
    logic       q_pop;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_volume <= MAX_VOLUME_RESET;
        end else if (cfg_write && reg_idx == REG_MAX_VOLUME) begin
            r_max_volume <= pwdata[VOL_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAX_VOLUME: prdata = {{(APB_DATA_W - VOL_W){1'b0}}, r_max_volume};
            REG_UNUSED:     prdata = '0;
            default:        prdata = '0;
        endcase
    end

    vfs_front #(
        .CHIP_COUNT (CHIP_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_max_volume (r_max_volume),
        .o_req_valid  (req_valid),
        .o_req        (req),
        .i_req_ready  (q_ready)
    );

    vfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (req_valid),
        .i_push_req (req),
        .o_ready    (q_ready),
        .o_valid    (q_valid),
        .o_req      (q_req),
        .i_pop      (q_pop)
    );

    vfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (q_valid),
        .i_req       (q_req),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the volume frame serializer: updates in, serial bits out.
`default_nettype none

module tb;
    import vfs_pkg::*;

    localparam int CHIP_COUNT   = 2;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_AFTER   = 70;
    localparam int HOLD_CYCLES  = 120;
    localparam int RUN_LIMIT    = 2_000_000;

    typedef struct packed {
        t_chip chip;
        logic  side;
        t_vol  volume;
    } t_update;

    typedef struct packed {
        t_chip clock_line;
        logic  data_bit;
        logic  latch_last;
    } t_serial_bit;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    vfs_in_if  upd_if ();
    vfs_out_if bit_if ();

    volume_frame_serializer #(
        .CHIP_COUNT(CHIP_COUNT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (upd_if),
        .o_out   (bit_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_update     updates_to_send[$];
    t_serial_bit serial_bits_due[$];
    t_vol        vol_limit;
    int          fail_count;
    int          updates_taken;
    int          gap_left;
    int          stall_left;
    int          hold_left;
    logic        hold_done;
    logic        calm;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expand one update for a known chip into its eleven serial bits, side bit first.
    function automatic void predict_frame(input t_update u);
        t_vol  level;
        t_code code;
        logic  bit_val;
        if (u.chip >= CHIP_COUNT)
            return;
        level = (u.volume > vol_limit) ? '0 : t_vol'(u.volume + VOL_OFFSET);
        code  = t_code'((level >> 2) | (level << 5)) | CODE_TOP_BIT;
        for (int k = 0; k < FRAME_BITS; k++) begin
            if (k == 0)
                bit_val = u.side;
            else if (k == FRAME_BITS - 1 || k == 1)
                bit_val = 1'b1;
            else
                bit_val = code[k-2];
            serial_bits_due.push_back('{u.chip, bit_val, logic'(k == FRAME_BITS - 1)});
        end
    endfunction

    // Sender: hold a request until taken, idle in short bursts between requests.
    always @(posedge i_clk) begin
        t_update nxt;
        if (!i_rst_n) begin
            upd_if.valid <= 1'b0;
            updates_taken <= 0;
            gap_left <= 0;
        end else begin
            if (upd_if.valid && upd_if.ready) begin
                predict_frame('{upd_if.chip_index, upd_if.right_side, upd_if.volume});
                updates_taken <= updates_taken + 1;
            end
            if (!(upd_if.valid && !upd_if.ready)) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    upd_if.valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    gap_left <= $urandom_range(0, 2);
                    upd_if.valid <= 1'b0;
                end else if (updates_to_send.size() != 0) begin
                    nxt = updates_to_send.pop_front();
                    upd_if.chip_index <= nxt.chip;
                    upd_if.right_side <= nxt.side;
                    upd_if.volume <= nxt.volume;
                    upd_if.valid <= 1'b1;
                end else begin
                    upd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once, so the front register and queue fill up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && updates_taken >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver: check each serial bit against the oldest one due.
    always @(posedge i_clk) begin
        t_serial_bit want;
        if (!i_rst_n) begin
            bit_if.ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (bit_if.valid && bit_if.ready) begin
                if (serial_bits_due.size() == 0) begin
                    $error("unexpected serial bit: clock_line %0d data_bit %0d latch_last %0d",
                           bit_if.clock_line, bit_if.data_bit, bit_if.latch_last);
                    fail_count++;
                end else begin
                    want = serial_bits_due.pop_front();
                    if (bit_if.clock_line !== want.clock_line) begin
                        $error("clock_line: expected %0d, got %0d",
                               want.clock_line, bit_if.clock_line);
                        fail_count++;
                    end
                    if (bit_if.data_bit !== want.data_bit) begin
                        $error("data_bit: expected %0d, got %0d",
                               want.data_bit, bit_if.data_bit);
                        fail_count++;
                    end
                    if (bit_if.latch_last !== want.latch_last) begin
                        $error("latch_last: expected %0d, got %0d",
                               want.latch_last, bit_if.latch_last);
                        fail_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                bit_if.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                bit_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 2);
                bit_if.ready <= 1'b0;
            end else begin
                bit_if.ready <= 1'b1;
            end
        end
    end

    task automatic queue_update(input t_chip chip, input logic side, input t_vol volume);
        updates_to_send.push_back('{chip, side, volume});
    endtask

    // Mostly addressed chips; some volumes cluster around the limit, the rest span the full range.
    task automatic queue_random_updates(input int count);
        t_chip chip;
        t_vol  volume;
        for (int n = 0; n < count; n++) begin
            chip = ($urandom_range(0, 4) == 0) ? t_chip'($urandom_range(0, 7))
                                               : t_chip'($urandom_range(0, CHIP_COUNT - 1));
            if ($urandom_range(0, 3) == 0)
                volume = t_vol'(vol_limit + $urandom_range(0, 2) - 1);
            else
                volume = t_vol'($urandom_range(0, 255));
            queue_update(chip, logic'($urandom_range(0, 1)), volume);
        end
    endtask

    // Wait until every request went in and every bit came out, then let dropped ones settle.
    task automatic drain();
        do
            @(negedge i_clk);
        while (updates_to_send.size() != 0 || upd_if.valid || serial_bits_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_max_volume(input t_vol value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_VOLUME, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        vol_limit = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[VOL_W-1:0] !== value) begin
            $error("max_volume: expected %0d, got %0d", value, prdata[VOL_W-1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        upd_if.valid      = 1'b0;
        upd_if.chip_index = '0;
        upd_if.right_side = 1'b0;
        upd_if.volume     = '0;
        bit_if.ready      = 1'b0;
        vol_limit         = MAX_VOLUME_RESET;
        fail_count        = 0;
        calm              = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset limit: floor, just under and at the limit, over it, top value.
        queue_update(3'd0, 1'b0, 8'd0);
        queue_update(3'd1, 1'b1, 8'd1);
        queue_update(3'd0, 1'b1, 8'd83);
        queue_update(3'd1, 1'b0, 8'd87);
        queue_update(3'd0, 1'b0, 8'd88);
        queue_update(3'd1, 1'b1, 8'd255);
        queue_update(3'd0, 1'b1, 8'd170);
        queue_update(3'd1, 1'b0, 8'd85);
        // Chips out of range are dropped.
        queue_update(3'd2, 1'b1, 8'd10);
        queue_update(3'd5, 1'b0, 8'd255);
        queue_update(3'd7, 1'b1, 8'd0);
        queue_update(3'd4, 1'b0, 8'd60);
        queue_update(3'd1, 1'b1, 8'd40);
        drain();

        // Top limit: offset add wraps around.
        set_max_volume(8'd255);
        @(negedge i_clk);
        queue_update(3'd0, 1'b0, 8'd251);
        queue_update(3'd1, 1'b1, 8'd252);
        queue_update(3'd0, 1'b1, 8'd253);
        queue_update(3'd1, 1'b0, 8'd255);
        queue_update(3'd0, 1'b0, 8'd0);
        drain();

        // Zero limit: only volume zero passes.
        set_max_volume(8'd0);
        @(negedge i_clk);
        queue_update(3'd0, 1'b1, 8'd0);
        queue_update(3'd1, 1'b0, 8'd1);
        queue_update(3'd0, 1'b0, 8'd255);
        drain();

        set_max_volume(t_vol'($urandom_range(1, 254)));
        @(negedge i_clk);
        queue_random_updates(40);
        drain();

        set_max_volume(8'd255);
        @(negedge i_clk);
        queue_random_updates(60);
        drain();

        set_max_volume(8'd0);
        @(negedge i_clk);
        queue_random_updates(35);
        drain();

        set_max_volume(t_vol'($urandom_range(1, 254)));
        @(negedge i_clk);
        queue_random_updates(40);
        drain();

        set_max_volume(MAX_VOLUME_RESET);
        @(negedge i_clk);
        queue_random_updates(40);
        drain();

        // Final stretch runs at full rate on both sides.
        set_max_volume(t_vol'($urandom_range(0, 255)));
        @(posedge i_clk);
        calm <= 1'b1;
        @(negedge i_clk);
        queue_random_updates(40);
        drain();

        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire
